// ----- design/pcq_pkg.sv -----
// shared constants and types for the per-class queue block
// no dependencies
package pcq_pkg;

    localparam int DEF_NUM_CLASSES = 16;
    localparam int DEF_SLOTS       = 8;
    localparam int DEF_ID_WIDTH    = 16;

    // fixed field widths at the ports
    localparam int CLS_SEL_W = 4;
    localparam int ID_PORT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED  = 2'd0,
        STS_FULL   = 2'd1,
        STS_SERVED = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_READ = 3'b100
    } t_state;

endpackage

// ----- design/pcq_slot_unit.sv -----
// shared modular slot adder: (base + offset) mod SLOTS
// depends on pcq_pkg for the default slot count
module pcq_slot_unit #(
    parameter int SLOTS  = pcq_pkg::DEF_SLOTS,
    parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOT_W-1:0] i_base,
    input  logic [SLOT_W-1:0] i_off,
    output logic [SLOT_W-1:0] o_slot
);
    import pcq_pkg::*;

    logic [SLOT_W:0] sum;

    always_comb begin
        sum = {1'b0, i_base} + {1'b0, i_off};
        // both operands stay below SLOTS, so one subtract wraps it
        if (32'(sum) >= SLOTS) begin
            sum = sum - (SLOT_W+1)'(SLOTS);
        end
        o_slot = sum[SLOT_W-1:0];
    end

endmodule

// ----- design/pcq_store.sv -----
// identifier store: one region of SLOTS entries per class, registered read
// depends on pcq_pkg for default sizes
module pcq_store #(
    parameter int NUM_CLASSES = pcq_pkg::DEF_NUM_CLASSES,
    parameter int SLOTS       = pcq_pkg::DEF_SLOTS,
    parameter int DATA_W      = pcq_pkg::DEF_ID_WIDTH,
    parameter int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    parameter int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [CLS_W-1:0]  i_cls,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    import pcq_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] addr;

    // region start is class * SLOTS
    assign addr = ADDR_W'(32'(i_cls) * SLOTS + 32'(i_slot));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[addr];
        end
    end

endmodule

// ----- design/per_class_queue_with_urgent_insert.sv -----
// top level of the per-class bounded queue with urgent head insert
// depends on pcq_pkg, pcq_slot_unit and pcq_store
//
// Keeps one bounded queue of identifiers per class. A request is taken at
// a clock edge with i_start high and o_busy low. An add (action 0) puts
// the identifier at the tail, or at the head when urgent is set; an add to
// a full class is rejected. A take (action 1) removes and returns the
// head, or reports that the class is empty. Every request yields exactly
// one result, shown for a single cycle with o_valid high; the receiver
// cannot stall, so the result must be captured in that cycle. Each class
// is a circular buffer with a head pointer and a count held in flops, so
// no entry ever moves. Timing: an add or any rejected request keeps
// o_busy high through S_CALC only; a successful take also passes through
// S_READ, set by the registered read of the single-port store and the
// second pass through the shared slot adder that advances the head. The
// result strobe rises at the same edge that drops o_busy, so the edge
// that ends the strobe may also accept the next request. No clearing pass
// is needed after reset: only counts and heads are cleared.
module per_class_queue_with_urgent_insert #(
    parameter int NUM_CLASSES = pcq_pkg::DEF_NUM_CLASSES,
    parameter int SLOTS       = pcq_pkg::DEF_SLOTS,
    parameter int ID_WIDTH    = pcq_pkg::DEF_ID_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_action,
    input  logic [pcq_pkg::CLS_SEL_W-1:0]  i_class_sel,
    input  logic                           i_urgent,
    input  logic [pcq_pkg::ID_PORT_W-1:0]  i_entry_id,
    output logic                           o_valid,
    output logic [pcq_pkg::STATUS_W-1:0]   o_status,
    output logic [pcq_pkg::ID_PORT_W-1:0]  o_served_id,
    output logic [pcq_pkg::COUNT_W-1:0]    o_count_after
);
    import pcq_pkg::*;

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    // stored ids only ever carry the low port bits
    localparam int SW     = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;

    // sequencer
    t_state r_state, n_state;

    // latched request
    logic             r_action;
    logic             r_urgent;
    logic             r_cls_ok;
    logic [CLS_W-1:0] r_cls;
    logic [SW-1:0]    r_id;
    logic [CNT_W-1:0] r_left;

    // per-class bookkeeping
    logic [CNT_W-1:0]  r_count [NUM_CLASSES];
    logic [SLOT_W-1:0] r_head  [NUM_CLASSES];

    // result register
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic [ID_PORT_W-1:0] r_served, n_served;
    logic [COUNT_W-1:0]   r_cnt_out, n_cnt_out;

    // datapath wiring
    logic [CNT_W-1:0]  cur_cnt;
    logic [SLOT_W-1:0] cur_head;
    logic [SLOT_W-1:0] unit_off;
    logic [SLOT_W-1:0] unit_slot;
    logic              mem_we, mem_re;
    logic              cnt_we, head_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [SW-1:0]     mem_rdata;

    assign cur_cnt  = r_count[r_cls];
    assign cur_head = r_head[r_cls];

    // offset picks what the shared adder computes this cycle
    always_comb begin
        unit_off = '0;
        if (r_state == S_READ) begin
            unit_off = SLOT_W'(1);                 // advance head after take
        end else if (!r_action) begin
            if (r_urgent) begin
                unit_off = SLOT_W'(SLOTS - 1);     // one place before head
            end else begin
                unit_off = cur_cnt[SLOT_W-1:0];    // tail slot, count below SLOTS
            end
        end
    end

    pcq_slot_unit #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_slot (
        .i_base (cur_head),
        .i_off  (unit_off),
        .o_slot (unit_slot)
    );

    pcq_store #(
        .NUM_CLASSES (NUM_CLASSES),
        .SLOTS       (SLOTS),
        .DATA_W      (SW),
        .CLS_W       (CLS_W),
        .SLOT_W      (SLOT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_cls   (r_cls),
        .i_slot  (unit_slot),
        .i_wdata (r_id),
        .o_rdata (mem_rdata)
    );

    // sequencer and result decisions
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_served  = '0;
        n_cnt_out = r_cnt_out;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        cnt_we    = 1'b0;
        head_we   = 1'b0;
        cnt_wdata = cur_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                if (!r_cls_ok) begin
                    // class without storage
                    n_status  = r_action ? STS_EMPTY : STS_FULL;
                    n_cnt_out = '0;
                end else if (!r_action) begin
                    if (32'(cur_cnt) >= SLOTS) begin
                        n_status  = STS_FULL;
                        n_cnt_out = COUNT_W'(cur_cnt);
                    end else begin
                        mem_we    = 1'b1;
                        cnt_we    = 1'b1;
                        head_we   = r_urgent;
                        cnt_wdata = cur_cnt + CNT_W'(1);
                        n_status  = STS_ADDED;
                        n_cnt_out = COUNT_W'(cnt_wdata);
                    end
                end else if (cur_cnt == '0) begin
                    n_status  = STS_EMPTY;
                    n_cnt_out = '0;
                end else begin
                    // read the head now, report once data is back
                    n_valid   = 1'b0;
                    mem_re    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = cur_cnt - CNT_W'(1);
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                head_we   = 1'b1;
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_status  = STS_SERVED;
                n_served  = ID_PORT_W'(mem_rdata);
                n_cnt_out = COUNT_W'(r_left);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= '0;
                r_head[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (cnt_we) begin
                r_count[r_cls] <= cnt_wdata;
            end
            if (head_we) begin
                r_head[r_cls] <= unit_slot;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_action <= i_action;
            r_urgent <= i_urgent;
            r_cls_ok <= (32'(i_class_sel) < NUM_CLASSES);
            r_cls    <= CLS_W'(i_class_sel);
            r_id     <= i_entry_id[SW-1:0];
        end
        if (r_state == S_CALC) begin
            r_left <= cnt_wdata;
        end
        r_status  <= n_status;
        r_served  <= n_served;
        r_cnt_out <= n_cnt_out;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_served_id   = r_served;
    assign o_count_after = r_cnt_out;

endmodule

// ----- test/per_class_queue_with_urgent_insert_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for per_class_queue_with_urgent_insert: directed corner cases, then random
// add/take traffic with random gaps, checked against a per-class queue predictor
// depends on pcq_pkg and the design files under design/
module per_class_queue_with_urgent_insert_tb;
    import pcq_pkg::*;

    localparam int NUM_CLASSES = DEF_NUM_CLASSES;
    localparam int SLOTS       = DEF_SLOTS;
    localparam int ID_WIDTH    = DEF_ID_WIDTH;
    localparam int RANDOM_REQS = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    localparam bit ACT_ADD  = 1'b0;
    localparam bit ACT_TAKE = 1'b1;

    localparam logic [ID_PORT_W-1:0] ID_KEEP = ID_PORT_W'((64'd1 << ID_WIDTH) - 64'd1);

    // one expected result, held until the strobe shows up
    typedef struct packed {
        t_status               status;
        logic [ID_PORT_W-1:0]  served_id;
        logic [COUNT_W-1:0]    count_after;
    } t_outcome;

    // predictor plus expected-result fifo
    class queue_checker;
        logic [ID_PORT_W-1:0] class_lanes[NUM_CLASSES][$];
        t_outcome             pending_outcomes[$];
        int                   mismatches;

        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // runs the queue update for one accepted request and files its result
        task note_request(input bit act, input logic [CLS_SEL_W-1:0] cls, input bit urg,
                          input logic [ID_PORT_W-1:0] id);
            t_outcome res;
            int       n;
            res = '{STS_ADDED, '0, '0};
            if (cls >= NUM_CLASSES) begin
                // class with no storage behind it
                res.status = (act == ACT_TAKE) ? STS_EMPTY : STS_FULL;
            end else begin
                n = class_lanes[cls].size();
                if (act == ACT_ADD) begin
                    if (n >= SLOTS) begin
                        res.status = STS_FULL;
                    end else begin
                        if (urg)
                            class_lanes[cls].push_front(id & ID_KEEP);
                        else
                            class_lanes[cls].push_back(id & ID_KEEP);
                        res.status = STS_ADDED;
                    end
                end else if (n == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.served_id = class_lanes[cls].pop_front();
                    res.status    = STS_SERVED;
                end
                res.count_after = COUNT_W'(class_lanes[cls].size());
            end
            pending_outcomes.push_back(res);
        endtask

        task check_result(input logic [STATUS_W-1:0] status,
                          input logic [ID_PORT_W-1:0] served_id,
                          input logic [COUNT_W-1:0] count_after);
            t_outcome exp_res;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (status %0d id %h cnt %0d)",
                                          status, served_id, count_after));
            end else begin
                exp_res = pending_outcomes.pop_front();
                if (status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %s", status,
                                              exp_res.status.name()));
                if (served_id !== exp_res.served_id)
                    report_mismatch($sformatf("served_id %h, expected %h", served_id,
                                              exp_res.served_id));
                if (count_after !== exp_res.count_after)
                    report_mismatch($sformatf("count_after %0d, expected %0d", count_after,
                                              exp_res.count_after));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_action;
    logic [CLS_SEL_W-1:0]  i_class_sel;
    logic                  i_urgent;
    logic [ID_PORT_W-1:0]  i_entry_id;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ID_PORT_W-1:0]  o_served_id;
    logic [COUNT_W-1:0]    o_count_after;

    queue_checker sb = new();
    int           cycle_count = 0;
    bit           idle_off;     // set for stretches of back-to-back requests

    per_class_queue_with_urgent_insert #(
        .NUM_CLASSES (NUM_CLASSES),
        .SLOTS       (SLOTS),
        .ID_WIDTH    (ID_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_action      (i_action),
        .i_class_sel   (i_class_sel),
        .i_urgent      (i_urgent),
        .i_entry_id    (i_entry_id),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_served_id   (o_served_id),
        .o_count_after (o_count_after)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // monitor: both sides sampled at the edge, before the design's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1)
                sb.check_result(o_status, o_served_id, o_count_after);
            if (i_start && !o_busy)
                sb.note_request(i_action, i_class_sel, i_urgent, i_entry_id);
        end
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drives one request and returns at the edge that accepts it; with no gap the
    // previous request's start simply stays high, so start gets one assignment per step
    task automatic send_request(input bit act, input logic [CLS_SEL_W-1:0] cls,
                                input bit urg, input logic [ID_PORT_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_action    <= act;
        i_class_sel <= cls;
        i_urgent    <= urg;
        i_entry_id  <= id;
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
    endtask

    initial begin
        int  add_bias;
        int  hot_base;
        bit  hot_mode;
        bit  act;
        logic [CLS_SEL_W-1:0] cls;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_action    <= 1'b0;
        i_class_sel <= '0;
        i_urgent    <= 1'b0;
        i_entry_id  <= '0;
        idle_off     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty take with the ignored fields set
        send_request(ACT_TAKE, 4'd0, 1'b1, 16'hFFFF);
        // id extremes, normal then urgent head insert
        send_request(ACT_ADD, 4'd0, 1'b0, 16'h0000);
        send_request(ACT_ADD, 4'd0, 1'b1, 16'hFFFF);
        // fill class 0 to the brim
        for (int k = 0; k < SLOTS - 2; k++)
            send_request(ACT_ADD, 4'd0, k[0], ID_PORT_W'(16'h1111 * (k + 1)));
        // full class: both flavors of add are refused
        send_request(ACT_ADD, 4'd0, 1'b1, 16'hA5A5);
        send_request(ACT_ADD, 4'd0, 1'b0, 16'h5A5A);
        // highest class: empty take, urgent add, take with junk in the ignored fields, empty take
        send_request(ACT_TAKE, 4'd15, 1'b0, 16'h0000);
        send_request(ACT_ADD, 4'd15, 1'b1, 16'hFFFF);
        send_request(ACT_TAKE, 4'd15, 1'b1, 16'h1234);
        send_request(ACT_TAKE, 4'd15, 1'b0, 16'hFFFF);
        // drain class 0 completely and once more past empty
        for (int k = 0; k < SLOTS + 1; k++)
            send_request(ACT_TAKE, 4'd0, k[0], 16'h0F0F);

        // random phases: add/take mix, class spread and idling change per phase;
        // hot phases pile requests onto two classes so full and empty both show up often
        for (int done = 0; done < RANDOM_REQS; ) begin
            add_bias = $urandom_range(15, 85);
            hot_mode = ($urandom_range(0, 99) < 60);
            hot_base = $urandom_range(0, NUM_CLASSES - 2);
            idle_off = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 120 && done < RANDOM_REQS; k++, done++) begin
                act = ($urandom_range(0, 99) < add_bias) ? ACT_ADD : ACT_TAKE;
                if (hot_mode)
                    cls = CLS_SEL_W'(hot_base + $urandom_range(0, 1));
                else
                    cls = CLS_SEL_W'($urandom_range(0, NUM_CLASSES - 1));
                send_request(act, cls, 1'($urandom_range(0, 1)), ID_PORT_W'($urandom));
            end
        end
        i_start <= 1'b0;

        // let every outstanding result come back, then a little slack for stray strobes
        while (sb.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
